// ----- sv/subsequence_match_scorer_unit_macros.svh -----
// Assertion macros used by the subsequence match scorer top file.
`ifndef SUBSEQUENCE_MATCH_SCORER_UNIT_MACROS_SVH
`define SUBSEQUENCE_MATCH_SCORER_UNIT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SMS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/sms_pkg.sv -----
// Types and constants shared by the subsequence match scorer modules.
`timescale 1ns / 1ps

package sms_pkg;

  localparam int PATTERN_BYTES = 16;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LENGTH = 2'd2;

  localparam logic FUNC_CHAR = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  localparam logic KIND_REPORT  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  typedef logic [PATTERN_BYTES-1:0][7:0] pattern_bytes_t;

  typedef struct packed {
    logic       func;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] position;
    logic        accepted;
    logic [15:0] first_position;
    logic [4:0]  longest_run;
  } out_item_t;

  typedef struct packed {
    pattern_bytes_t pattern;
    logic [4:0]     length;
  } pattern_cfg_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

endpackage

// ----- sv/sms_cfg_regs.sv -----
// Configuration registers holding the pattern bytes and the pattern length.
`timescale 1ns / 1ps

module sms_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sms_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [63:0]                        cfg_data_i,
  output sms_pkg::pattern_cfg_t              cfg_o
);
  import sms_pkg::*;

  logic [63:0] low_q;
  logic [63:0] high_q;
  logic [4:0]  length_q;
  logic        write;

  assign cfg_ready_o = 1'b1;
  assign write = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q    <= '0;
      high_q   <= '0;
      length_q <= '0;
    end else if (write) begin
      case (cfg_index_i)
        CFG_PATTERN_LOW:    low_q    <= cfg_data_i;
        CFG_PATTERN_HIGH:   high_q   <= cfg_data_i;
        CFG_PATTERN_LENGTH: length_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.pattern = pattern_bytes_t'({high_q, low_q});
  assign cfg_o.length  = length_q;

endmodule

// ----- sv/sms_match_core.sv -----
// Input register, match state and the combinational match and summary logic.
`timescale 1ns / 1ps

module sms_match_core #(
  parameter int MAX_PATTERN   = 16,
  parameter int POSITION_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sms_pkg::in_item_t     in_data_i,
  input  sms_pkg::pattern_cfg_t cfg_i,
  input  logic                  advance_i,
  output sms_pkg::result_t      res_o
);
  import sms_pkg::*;

  localparam int IDX_W = $clog2(MAX_PATTERN + 1);
  localparam int PW1   = POSITION_BITS + 1;
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  logic                     in_valid_q;
  in_item_t                 in_q;
  logic                     fire;
  logic                     accept;

  logic [IDX_W-1:0]         idx_q, idx_d;
  logic [POSITION_BITS-1:0] char_pos_q, char_pos_d;
  logic [POSITION_BITS-1:0] prev_q, prev_d;
  logic [POSITION_BITS-1:0] earliest_q, earliest_d;
  logic [IDX_W-1:0]         cur_run_q, cur_run_d;
  logic [IDX_W-1:0]         best_run_q, best_run_d;
  logic                     complete_q, complete_d;

  logic [4:0]               eff_len5;
  logic [IDX_W-1:0]         eff_len;
  logic [7:0]               folded;
  logic [7:0]               pat_byte;
  logic                     hit;
  logic                     adjacent;
  logic [IDX_W-1:0]         idx_inc;
  logic [IDX_W-1:0]         run_new;
  logic [PW1-1:0]           prev_inc;
  logic [31:0]              pos_ext;
  logic [31:0]              earliest_ext;

  // The input stage moves on whenever the result register can take a beat.
  assign in_stall_o = in_valid_q & ~advance_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign fire       = in_valid_q & advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  assign eff_len5 = (cfg_i.length > 5'(MAX_PATTERN)) ? 5'(MAX_PATTERN) : cfg_i.length;
  assign eff_len  = IDX_W'(eff_len5);

  always_comb begin
    folded = in_q.char_code;
    if (in_q.char_code >= CHAR_UPPER_A && in_q.char_code <= CHAR_UPPER_Z) begin
      folded = in_q.char_code + CASE_OFFSET;
    end
  end

  assign pat_byte = cfg_i.pattern[4'(idx_q)];
  assign hit      = (in_q.func == FUNC_CHAR) && !complete_q && (idx_q < eff_len) &&
                    (folded == pat_byte);
  // A saturated position that repeats the previous match is not adjacent.
  assign prev_inc = {1'b0, prev_q} + PW1'(1);
  assign adjacent = (prev_inc == {1'b0, char_pos_q});
  assign idx_inc  = idx_q + IDX_W'(1);

  always_comb begin
    if (idx_q == '0) begin
      run_new = IDX_W'(1);
    end else if (adjacent) begin
      run_new = cur_run_q + IDX_W'(1);
    end else begin
      run_new = IDX_W'(1);
    end
  end

  always_comb begin
    idx_d      = idx_q;
    char_pos_d = char_pos_q;
    prev_d     = prev_q;
    earliest_d = earliest_q;
    cur_run_d  = cur_run_q;
    best_run_d = best_run_q;
    complete_d = complete_q;
    if (in_q.func == FUNC_END) begin
      idx_d      = '0;
      char_pos_d = '0;
      prev_d     = '0;
      earliest_d = '0;
      cur_run_d  = '0;
      best_run_d = '0;
      complete_d = 1'b0;
    end else begin
      if (hit) begin
        if (idx_q == '0) begin
          earliest_d = char_pos_q;
        end
        cur_run_d = run_new;
        if (run_new > best_run_q) begin
          best_run_d = run_new;
        end
        prev_d = char_pos_q;
        idx_d  = idx_inc;
        if (idx_inc >= eff_len) begin
          complete_d = 1'b1;
        end
      end
      if (char_pos_q != POS_MAX) begin
        char_pos_d = char_pos_q + POSITION_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      char_pos_q <= '0;
      prev_q     <= '0;
      earliest_q <= '0;
      cur_run_q  <= '0;
      best_run_q <= '0;
      complete_q <= 1'b0;
    end else if (fire) begin
      idx_q      <= idx_d;
      char_pos_q <= char_pos_d;
      prev_q     <= prev_d;
      earliest_q <= earliest_d;
      cur_run_q  <= cur_run_d;
      best_run_q <= best_run_d;
      complete_q <= complete_d;
    end
  end

  assign pos_ext      = 32'(char_pos_q);
  assign earliest_ext = 32'(earliest_q);

  always_comb begin
    res_o       = '0;
    res_o.valid = fire && ((in_q.func == FUNC_END) || hit);
    if (in_q.func == FUNC_END) begin
      res_o.item.kind = KIND_SUMMARY;
      if (complete_q) begin
        res_o.item.accepted       = 1'b1;
        res_o.item.first_position = earliest_ext[15:0];
        res_o.item.longest_run    = 5'(best_run_q);
      end
    end else begin
      res_o.item.kind     = KIND_REPORT;
      res_o.item.position = pos_ext[15:0];
    end
  end

endmodule

// ----- sv/sms_out_reg.sv -----
// Result register that holds a beat while the receiver stalls.
`timescale 1ns / 1ps

module sms_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sms_pkg::result_t   res_i,
  output logic               advance_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sms_pkg::out_item_t out_data_o
);
  import sms_pkg::*;

  logic      valid_q, valid_d;
  out_item_t data_q;

  assign advance_o = ~valid_q | ~out_stall_i;

  always_comb begin
    valid_d = valid_q & out_stall_i;
    if (advance_o && res_i.valid) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_i.valid) begin
      data_q <= res_i.item;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ----- sv/subsequence_match_scorer_unit.sv -----
// Subsequence match scorer: streams candidate characters against a configured pattern.
//
// Input channel: one beat per candidate character (func = 0) or end marker (func = 1).
// Characters are folded to lower case and matched greedily against the pattern.
// Each matching character gives a report beat with its position; each end marker
// gives a summary beat (accepted, first position, longest adjacent run) and clears
// the match state for the next candidate.
// Configuration: index 0 and 1 take pattern bytes 0-7 and 8-15, index 2 the length.
// The port is always ready; the user makes writes only while no beat is in flight, and
// the block does not enforce it. A beat taken into the input register passes the match
// logic into the result register, from which its result leaves.
// Throughput: one input beat per cycle while the receiver does not stall, set by the single
// match stage between the input register and the result register.
// A stalled result stays in the result register; the input register keeps one more
// beat, after which in_stall_o rises until the receiver takes the result.
// Reset clears the pattern, the length, the match state and both valid flags.
`timescale 1ns / 1ps
`include "subsequence_match_scorer_unit_macros.svh"

module subsequence_match_scorer_unit #(
  parameter int MAX_PATTERN   = 16,
  parameter int POSITION_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  sms_pkg::in_item_t                  in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output sms_pkg::out_item_t                 out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sms_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [63:0]                        cfg_data_i
);
  import sms_pkg::*;

  pattern_cfg_t cfg;
  result_t      res;
  logic         advance;

  sms_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sms_match_core #(
    .MAX_PATTERN   (MAX_PATTERN),
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg),
    .advance_i  (advance),
    .res_o      (res)
  );

  sms_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `SMS_ASSERT_SAME(a_stall_only_when_blocked, in_stall_o, out_valid_o && out_stall_i, "input stalled while the result register could move")
  `SMS_ASSERT_SAME(a_report_clean, out_valid_o && out_data_o.kind == KIND_REPORT, !out_data_o.accepted && out_data_o.first_position == 16'd0 && out_data_o.longest_run == 5'd0, "report beat carries summary fields")
  `SMS_ASSERT_SAME(a_reject_clean, out_valid_o && out_data_o.kind == KIND_SUMMARY && !out_data_o.accepted, out_data_o.first_position == 16'd0 && out_data_o.longest_run == 5'd0 && out_data_o.position == 16'd0, "rejected summary carries nonzero fields")
  `SMS_ASSERT_SAME(a_accept_run, out_valid_o && out_data_o.kind == KIND_SUMMARY && out_data_o.accepted, out_data_o.longest_run != 5'd0 && out_data_o.longest_run <= 5'(MAX_PATTERN), "accepted summary has a run out of range")
  `SMS_ASSERT_NEXT(a_hold_when_stalled, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")

endmodule

// ----- verif/subsequence_match_scorer_unit_checker.sv -----
// Checker for the subsequence match scorer: predicts every result beat and compares it.
`timescale 1ns / 1ps

module subsequence_match_scorer_unit_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  sms_pkg::in_item_t                  in_data_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  sms_pkg::out_item_t                 out_data_i,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [sms_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [63:0]                        cfg_data_i,
  output int                                 fail_count_o,
  output int                                 pending_o,
  output int                                 char_beats_o,
  output int                                 end_beats_o,
  output int                                 accepted_o
);
  import sms_pkg::*;

  pattern_bytes_t pattern_q;
  logic [4:0]     length_q;

  logic [4:0]  match_index;
  logic [15:0] char_pos;
  logic [15:0] last_match_pos;
  logic [15:0] first_match_pos;
  logic [4:0]  run_len;
  logic [4:0]  best_run_len;
  logic        done_flag;

  out_item_t expected_results[$];

  function automatic void clear_match();
    match_index     = '0;
    char_pos        = '0;
    last_match_pos  = '0;
    first_match_pos = '0;
    run_len         = '0;
    best_run_len    = '0;
    done_flag       = 1'b0;
  endfunction

  // Advances the match state by one beat; returns 1 when the beat yields a result.
  function automatic bit score_beat(input in_item_t beat, output out_item_t res);
    logic [7:0] folded;
    logic [4:0] span;
    bit         hit;
    res = '0;
    if (beat.func == FUNC_END) begin
      res.kind           = KIND_SUMMARY;
      res.accepted       = done_flag;
      res.first_position = done_flag ? first_match_pos : 16'd0;
      res.longest_run    = done_flag ? best_run_len : 5'd0;
      clear_match();
      return 1'b1;
    end
    span = (length_q > PATTERN_BYTES) ? 5'(PATTERN_BYTES) : length_q;
    folded = beat.char_code;
    if (folded >= CHAR_UPPER_A && folded <= CHAR_UPPER_Z) begin
      folded = folded + CASE_OFFSET;
    end
    hit = !done_flag && (match_index < span) && (folded == pattern_q[match_index[3:0]]);
    if (hit) begin
      if (match_index == 0) begin
        first_match_pos = char_pos;
        run_len = 5'd1;
      end else if ({1'b0, last_match_pos} + 17'd1 == {1'b0, char_pos}) begin
        // A saturated position repeating the last match fails this test on purpose.
        run_len = run_len + 5'd1;
      end else begin
        run_len = 5'd1;
      end
      if (run_len > best_run_len) best_run_len = run_len;
      last_match_pos = char_pos;
      match_index = match_index + 5'd1;
      if (match_index >= span) done_flag = 1'b1;
      res.kind     = KIND_REPORT;
      res.position = char_pos;
    end
    if (char_pos != 16'hFFFF) char_pos = char_pos + 16'd1;
    return hit;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    out_item_t predicted;
    if (!rst_ni) begin
      pattern_q    = '0;
      length_q     = '0;
      clear_match();
      expected_results.delete();
      fail_count_o = 0;
      char_beats_o = 0;
      end_beats_o  = 0;
      accepted_o   = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: kind %0d position %0d",
                 out_data_i.kind, out_data_i.position);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", want.kind, out_data_i.kind);
          check_field("position", want.position, out_data_i.position);
          check_field("accepted", want.accepted, out_data_i.accepted);
          check_field("first_position", want.first_position, out_data_i.first_position);
          check_field("longest_run", want.longest_run, out_data_i.longest_run);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_PATTERN_LOW:    pattern_q[7:0]  = cfg_data_i;
          CFG_PATTERN_HIGH:   pattern_q[15:8] = cfg_data_i;
          CFG_PATTERN_LENGTH: length_q        = cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.func == FUNC_END) end_beats_o++;
        else char_beats_o++;
        if (score_beat(in_data_i, predicted)) begin
          expected_results = {expected_results, predicted};
          if (predicted.kind == KIND_SUMMARY && predicted.accepted) accepted_o++;
        end
      end
    end
    pending_o = expected_results.size();
  end

endmodule

// ----- verif/subsequence_match_scorer_unit_tb.sv -----
// Testbench top for the subsequence match scorer: stimulus, idling and the verdict.
`timescale 1ns / 1ps

module subsequence_match_scorer_unit_tb;
  import sms_pkg::*;

  localparam int RANDOM_ITEMS   = 500;
  localparam int RANDOM_BLOCKS  = 12;
  localparam int DRAIN_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                      in_valid_i  = 1'b0;
  logic                      in_stall_o;
  in_item_t                  in_data_i   = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  out_item_t                 out_data_o;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [CFG_INDEX_BITS-1:0] cfg_index_i = '0;
  logic [63:0]               cfg_data_i  = '0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int          items_sent     = 0;
  int          quiet_cycles   = 0;

  int fail_count;
  int pending;
  int char_beats;
  int end_beats;
  int accepted_count;

  subsequence_match_scorer_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  subsequence_match_scorer_unit_checker match_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .char_beats_o (char_beats),
    .end_beats_o  (end_beats),
    .accepted_o   (accepted_count)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("Watchdog expired after %0d cycles without a beat.", WATCHDOG_LIMIT);
    $display("subsequence_match_scorer_unit_tb: FAIL");
    $finish;
  end

  task automatic send_beat(input logic func, input logic [7:0] code);
    in_item_t beat;
    beat.func      = func;
    beat.char_code = code;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Leaves cfg_valid_i high; set_pattern lowers it after the last write.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [63:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic set_pattern(input pattern_bytes_t pat, input logic [63:0] len_word);
    write_reg(CFG_PATTERN_LOW, pat[7:0]);
    write_reg(CFG_PATTERN_HIGH, pat[15:8]);
    write_reg(CFG_PATTERN_LENGTH, len_word);
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every predicted result is out, then DRAIN_CYCLES longer for beats that
  // made no result and may still sit in the pipeline.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Mostly well-formed candidates with noise between pattern bytes, now and then with a
  // pattern byte dropped; the rest are pure noise.
  task automatic send_candidate(input pattern_bytes_t pat, input int span);
    logic [7:0] ch;
    if ($urandom_range(0, 99) < 75) begin
      for (int i = 0; i < span; i++) begin
        if ($urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(1, 3)) send_beat(FUNC_CHAR, 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 99) >= 8) begin
          ch = pat[i];
          if (ch >= CHAR_UPPER_A + CASE_OFFSET && ch <= CHAR_UPPER_Z + CASE_OFFSET &&
              $urandom_range(0, 1) == 1) begin
            ch = ch - CASE_OFFSET;
          end
          send_beat(FUNC_CHAR, ch);
        end
      end
      repeat ($urandom_range(0, 2)) send_beat(FUNC_CHAR, 8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 6)) send_beat(FUNC_CHAR, 8'($urandom_range(0, 255)));
    end
    send_beat(FUNC_END, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    pattern_bytes_t pat;
    logic [63:0]    len_word;
    int             len;
    int             start;
    int             pick;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty pattern after reset: the candidate is rejected.
    send_beat(FUNC_CHAR, "A");
    send_beat(FUNC_END, 8'hFF);

    // Case folding at the edges of A-Z; a character after the full match is ignored.
    wait_idle();
    pat = '1;
    pat[7:0] = '0;
    pat[0] = "a";
    pat[1] = "z";
    pat[2] = "[";
    pat[3] = "@";
    set_pattern(pat, 64'd4);
    send_beat(FUNC_CHAR, "x");
    send_beat(FUNC_CHAR, "A");
    send_beat(FUNC_CHAR, "Z");
    send_beat(FUNC_CHAR, "[");
    send_beat(FUNC_CHAR, "@");
    send_beat(FUNC_CHAR, "a");
    send_beat(FUNC_END, 8'h00);

    // Length cut below the match index in the middle of a candidate.
    send_beat(FUNC_CHAR, "a");
    send_beat(FUNC_CHAR, "z");
    wait_idle();
    set_pattern(pat, 64'd1);
    send_beat(FUNC_CHAR, "[");
    send_beat(FUNC_END, 8'h5A);

    // Full sixteen byte pattern of extreme byte values, matched in one run.
    wait_idle();
    pat[7:0]  = '0;
    pat[15:8] = '1;
    set_pattern(pat, 64'd16);
    for (int i = 0; i < 16; i++) send_beat(FUNC_CHAR, pat[i]);
    send_beat(FUNC_END, 8'hA5);

    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      wait_idle();
      case (blk % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      for (int i = 0; i < PATTERN_BYTES; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) pat[i] = 8'($urandom_range(8'h61, 8'h7A));
        else if (pick < 85) pat[i] = 8'($urandom_range(CHAR_UPPER_A, CHAR_UPPER_Z));
        else pat[i] = 8'($urandom_range(0, 255));
      end
      case (blk)
        0: len = 16;
        1: len = 31;
        2: len = 0;
        default: len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 31)
                                                   : $urandom_range(1, 8);
      endcase
      // Bits above the length field carry noise that the block must drop.
      len_word = {$urandom(), $urandom()};
      len_word[4:0] = 5'(len);
      set_pattern(pat, len_word);
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS / RANDOM_BLOCKS) begin
        send_candidate(pat, (len > PATTERN_BYTES) ? PATTERN_BYTES : len);
      end
    end

    wait_idle();
    $display("Run covered %0d character beats and %0d end beats, %0d candidates accepted,",
             char_beats, end_beats, accepted_count);
    $display("over pattern lengths 0 to 31, case folding edges and four idling mixes.");
    if (fail_count == 0) begin
      $display("subsequence_match_scorer_unit_tb: PASS");
    end else begin
      $display("subsequence_match_scorer_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
